// ===== hdl/pf_pkg.sv =====
// shared types, constants and helper functions for the playfair digram encryptor
package pf_pkg;

  localparam int Alphabet = 26;
  localparam int Cells = 25;
  localparam int Side = 5;
  localparam int LetterBits = 5;

  typedef logic [LetterBits-1:0] letter_t;
  typedef logic [LetterBits-1:0] pos_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LetterJ = letter_t'(9);
  localparam letter_t LetterI = letter_t'(8);
  localparam letter_t LetterZ = letter_t'(Alphabet - 1);

  typedef enum logic [1:0] {
    CMD_KEY     = 2'd0,
    CMD_KEY_END = 2'd1,
    CMD_ENCRYPT = 2'd2
  } pf_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_LOOKUP,
    ST_FINISH
  } pf_state_t;

  // a pair of square positions, first and second letter
  typedef struct packed {
    pos_t pos_a;
    pos_t pos_b;
  } cell_pair_t;

  // out-of-range codes saturate to z, then j folds onto i
  function automatic letter_t fold_letter(input letter_t raw);
    letter_t v;
    v = (raw > LetterZ) ? LetterZ : raw;
    if (v == LetterJ) begin
      v = LetterI;
    end
    return v;
  endfunction

  // row of a square position, by comparison against the row starts
  function automatic coord_t pos_row(input pos_t p);
    coord_t r;
    if (p >= pos_t'(4 * Side)) r = 3'd4;
    else if (p >= pos_t'(3 * Side)) r = 3'd3;
    else if (p >= pos_t'(2 * Side)) r = 3'd2;
    else if (p >= pos_t'(Side)) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // first position of a row: row * 5
  function automatic pos_t row_base(input coord_t r);
    return pos_t'({r, 2'b00}) + pos_t'(r);
  endfunction

  function automatic coord_t pos_col(input pos_t p);
    pos_t d;
    d = p - row_base(pos_row(p));
    return d[2:0];
  endfunction

  // step one place with wraparound inside the side
  function automatic coord_t wrap_inc(input coord_t c);
    return (c == coord_t'(Side - 1)) ? 3'd0 : c + 3'd1;
  endfunction

endpackage

// ===== hdl/playfair_digram_encryptor.sv =====
// top level of the playfair digram encryptor: key square build and pair encryption
//
// The block keeps the 5x5 key square in two small synchronous memories: one
// maps a square position to its letter, the other maps a letter to its
// position; a row of 26 used flags in flip-flops tracks which letters are
// placed. Commands arrive on s_tuser. A key letter is written in its transfer
// cycle (a key letter that arrives on a finished square first drops the old
// key). A key end walks the alphabet one letter per cycle through the shared
// write port, so it holds the input until the walk is done, and then marks
// the square ready; on a ready square it does nothing. An encrypt transfer
// runs in steps: the two position lookups read in the transfer cycle, the two
// square reads follow in the lookup state, and the result lands in the output
// register once that register is free; one item is at work at a time. An
// encrypt on a square that is not ready skips the square reads and yields a
// result with not_ready set and both letters zero. The output register lets a
// new transfer in while a result still waits on m_tready. Command code 3 is
// ignored and gives no result.
module playfair_digram_encryptor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // letter_one [4:0], letter_two [9:5], zero fill
  input  logic [1:0]  s_tuser,   // command [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // cipher_one [4:0], cipher_two [9:5], zero fill
  output logic [0:0]  m_tuser    // not_ready [0]
);
  import pf_pkg::*;

  pf_state_t state, state_next;

  // square memories
  letter_t square_mem [Cells];
  pos_t    pos_mem [Alphabet];

  logic [Alphabet-1:0] letter_used, used_next;
  pos_t    fill_count, fill_next;
  logic    square_ready, ready_next;
  letter_t walk_k;
  logic    flag_q;

  logic    wr_en;
  letter_t wr_letter;
  pos_t    wr_pos;

  pos_t    pos_rd_a, pos_rd_b;
  letter_t sq_rd_a, sq_rd_b;

  cell_pair_t pos_pair, cell_pair;

  pf_cmd_t cmd;
  letter_t letter_one, letter_two;
  logic    accept;
  logic    out_free;

  assign cmd        = pf_cmd_t'(s_tuser);
  assign letter_one = s_tdata[4:0];
  assign letter_two = s_tdata[9:5];
  assign accept     = s_tvalid && s_tready;
  // the output register can take a result this cycle
  assign out_free   = !m_tvalid || m_tready;

  assign pos_pair.pos_a = pos_rd_a;
  assign pos_pair.pos_b = pos_rd_b;

  pf_cell_map u_cell_map (
    .pos    (pos_pair),
    .mapped (cell_pair)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_KEY_END: begin
              if (!square_ready) state_next = ST_WALK;
            end
            CMD_ENCRYPT: begin
              state_next = square_ready ? ST_LOOKUP : ST_FINISH;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_k == LetterZ) state_next = ST_IDLE;
      end
      ST_LOOKUP: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    s_tready = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_WALK, ST_LOOKUP, ST_FINISH: s_tready = 1'b0;
      default: s_tready = 1'b0;
    endcase
  end

  // key placement: one write per cycle into both memories
  always_comb begin
    used_next  = letter_used;
    fill_next  = fill_count;
    ready_next = square_ready;
    wr_en      = 1'b0;
    wr_letter  = walk_k;
    wr_pos     = fill_count;
    if (accept && cmd == CMD_KEY) begin
      if (square_ready) begin
        // new key on a finished square
        used_next  = '0;
        fill_next  = '0;
        ready_next = 1'b0;
      end
      wr_letter = letter_one;
      wr_pos    = fill_next;
      if (letter_one <= LetterZ && letter_one != LetterJ && !used_next[letter_one]
          && fill_next < pos_t'(Cells)) begin
        wr_en                = 1'b1;
        used_next[letter_one] = 1'b1;
        fill_next            = fill_next + pos_t'(1);
      end
    end else if (state == ST_WALK) begin
      if (walk_k != LetterJ && !letter_used[walk_k] && fill_count < pos_t'(Cells)) begin
        wr_en             = 1'b1;
        used_next[walk_k] = 1'b1;
        fill_next         = fill_count + pos_t'(1);
      end
      if (walk_k == LetterZ) ready_next = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      letter_used  <= '0;
      fill_count   <= '0;
      square_ready <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      state        <= state_next;
      letter_used  <= used_next;
      fill_count   <= fill_next;
      square_ready <= ready_next;
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // walk counter and pending flag
  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      walk_k <= '0;
    end else if (state == ST_WALK) begin
      walk_k <= walk_k + letter_t'(1);
    end
    if (accept) begin
      flag_q <= !square_ready;
    end
  end

  // memories: writes in idle or walk; position reads on every accepted transfer,
  // square reads in the lookup state
  always_ff @(posedge clk) begin
    if (wr_en) begin
      square_mem[wr_pos] <= wr_letter;
      pos_mem[wr_letter] <= wr_pos;
    end
    if (accept) begin
      pos_rd_a <= pos_mem[fold_letter(letter_one)];
      pos_rd_b <= pos_mem[fold_letter(letter_two)];
    end
    if (state == ST_LOOKUP) begin
      sq_rd_a <= square_mem[cell_pair.pos_a];
      sq_rd_b <= square_mem[cell_pair.pos_b];
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      m_tdata <= flag_q ? '0 : {6'b0, sq_rd_b, sq_rd_a};
      m_tuser <= flag_q;
    end
  end

`ifndef SYNTHESIS
  // a ready square holds all 25 letters
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    square_ready |-> fill_count == pos_t'(Cells))
    else $error("square ready with fill count %0d", fill_count);

  // fill count tracks the used flags
  a_used_count: assert property (@(posedge clk) disable iff (rst)
    $countones(letter_used) == int'(fill_count))
    else $error("used flags disagree with fill count");

  // the alphabet walk runs only on an unfinished square
  a_walk_not_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> !square_ready)
    else $error("walk on a ready square");

  // a flagged result carries zero letters
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("not ready result with nonzero letters");
`endif

endmodule

// ===== hdl/pf_cell_map.sv =====
// playfair rules: maps the two plaintext positions to the two ciphertext positions
module pf_cell_map (
  input  pf_pkg::cell_pair_t pos,
  output pf_pkg::cell_pair_t mapped
);
  import pf_pkg::*;

  coord_t row_a, col_a, row_b, col_b;

  assign row_a = pos_row(pos.pos_a);
  assign col_a = pos_col(pos.pos_a);
  assign row_b = pos_row(pos.pos_b);
  assign col_b = pos_col(pos.pos_b);

  always_comb begin
    if (row_a == row_b) begin
      // same row, doubled letters included: shift right
      mapped.pos_a = row_base(row_a) + pos_t'(wrap_inc(col_a));
      mapped.pos_b = row_base(row_b) + pos_t'(wrap_inc(col_b));
    end else if (col_a == col_b) begin
      // same column: shift down
      mapped.pos_a = row_base(wrap_inc(row_a)) + pos_t'(col_a);
      mapped.pos_b = row_base(wrap_inc(row_b)) + pos_t'(col_b);
    end else begin
      // rectangle: swap columns
      mapped.pos_a = row_base(row_a) + pos_t'(col_b);
      mapped.pos_b = row_base(row_b) + pos_t'(col_a);
    end
  end

endmodule

// ===== bench/tb_playfair_digram_encryptor.sv =====
// self-checking testbench for the playfair digram encryptor: directed table plus random key sessions
module tb_playfair_digram_encryptor;
  import pf_pkg::*;

  localparam int RandomItems = 1100;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;
  // command code that the block must ignore
  localparam logic [1:0] CmdIgnored = 2'd3;

  // one result: cipher_one, cipher_two, not_ready
  typedef struct packed {
    letter_t one;
    letter_t two;
    logic    not_ready;
  } cipher_t;

  // one stimulus row; want is only used where typed is set
  typedef struct packed {
    logic [1:0] cmd;
    letter_t    l1;
    letter_t    l2;
    logic       typed;
    cipher_t    want;
  } stim_t;

  localparam int DirectedCount = 24;

  // directed rows: extremes, every command, the special cases
  localparam stim_t DirectedTable [DirectedCount] = '{
    // encrypt straight after reset: flagged, letters zero
    '{CMD_ENCRYPT, 5'd0, 5'd0, 1'b1, '{5'd0, 5'd0, 1'b1}},
    // key letter j is dropped, so is an out-of-range code
    '{CMD_KEY, 5'd9, 5'd31, 1'b0, '0},
    '{CMD_KEY, 5'd31, 5'd0, 1'b0, '0},
    // empty key: the square is the plain alphabet without j
    '{CMD_KEY_END, 5'd0, 5'd0, 1'b0, '0},
    // second key end on a ready square does nothing
    '{CMD_KEY_END, 5'd31, 5'd31, 1'b0, '0},
    // a,b share the top row: b,c
    '{CMD_ENCRYPT, 5'd0, 5'd1, 1'b1, '{5'd1, 5'd2, 1'b0}},
    // both saturate to z, doubled, wrap to the row start: v,v
    '{CMD_ENCRYPT, 5'd31, 5'd31, 1'b1, '{5'd21, 5'd21, 1'b0}},
    '{CMD_ENCRYPT, 5'd9, 5'd0, 1'b0, '0},
    '{CMD_ENCRYPT, 5'd0, 5'd5, 1'b0, '0},
    '{CMD_ENCRYPT, 5'd24, 5'd2, 1'b0, '0},
    '{CmdIgnored, 5'd31, 5'd31, 1'b0, '0},
    // key letter on a ready square drops the old key
    '{CMD_KEY, 5'd15, 5'd0, 1'b0, '0},
    '{CMD_KEY, 5'd11, 5'd17, 1'b0, '0},
    '{CMD_KEY, 5'd0, 5'd0, 1'b0, '0},
    '{CMD_KEY, 5'd24, 5'd0, 1'b0, '0},
    // repeated key letter is skipped
    '{CMD_KEY, 5'd11, 5'd0, 1'b0, '0},
    '{CMD_KEY, 5'd9, 5'd0, 1'b0, '0},
    // square under construction: flagged
    '{CMD_ENCRYPT, 5'd7, 5'd4, 1'b1, '{5'd0, 5'd0, 1'b1}},
    '{CMD_KEY, 5'd5, 5'd0, 1'b0, '0},
    '{CMD_KEY_END, 5'd0, 5'd0, 1'b0, '0},
    '{CMD_ENCRYPT, 5'd7, 5'd8, 1'b0, '0},
    '{CMD_ENCRYPT, 5'd9, 5'd9, 1'b0, '0},
    '{CMD_ENCRYPT, 5'd26, 5'd30, 1'b0, '0},
    '{CMD_ENCRYPT, 5'd4, 5'd23, 1'b0, '0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // letter_one [4:0], letter_two [9:5], zero fill
  logic [1:0]  s_tuser;   // command [1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // cipher_one [4:0], cipher_two [9:5], zero fill
  logic [0:0]  m_tuser;   // not_ready [0]

  playfair_digram_encryptor u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predictor copy of the key square
  letter_t sq_letter [Cells];
  pos_t    sq_pos [Alphabet];
  bit      placed [Alphabet];
  int      fill_n;
  bit      sq_ready;

  stim_t   stimulus [$];
  cipher_t pending_ciphers [$];
  int      mismatch_count;
  int      cycle_count;
  bit      source_quiet;
  bit      sink_quiet;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // append a letter to the square unless it is j, out of range or already in
  task automatic place_key_letter(input int ltr);
    if (ltr < Alphabet && ltr != int'(LetterJ) && !placed[ltr] && fill_n < Cells) begin
      sq_letter[fill_n] = letter_t'(ltr);
      sq_pos[ltr] = pos_t'(fill_n);
      placed[ltr] = 1'b1;
      fill_n++;
    end
  endtask

  // saturate to z, fold j onto i
  function automatic int plain_index(input letter_t raw);
    int v;
    v = (int'(raw) > int'(LetterZ)) ? int'(LetterZ) : int'(raw);
    if (v == int'(LetterJ)) v = int'(LetterI);
    return v;
  endfunction

  // advance the square copy by one item; encrypt items yield a cipher pair
  task automatic playfair_predict(input stim_t it, output bit has_out, output cipher_t res);
    int pa, pb, ra, ca, rb, cb, oa, ob;
    has_out = 1'b0;
    res = '0;
    case (it.cmd)
      CMD_KEY: begin
        if (sq_ready) begin
          foreach (placed[k]) placed[k] = 1'b0;
          fill_n = 0;
          sq_ready = 1'b0;
        end
        place_key_letter(int'(it.l1));
      end
      CMD_KEY_END: begin
        if (!sq_ready) begin
          for (int k = 0; k < Alphabet; k++) place_key_letter(k);
          sq_ready = 1'b1;
        end
      end
      CMD_ENCRYPT: begin
        has_out = 1'b1;
        if (!sq_ready) begin
          res.not_ready = 1'b1;
        end else begin
          pa = int'(sq_pos[plain_index(it.l1)]);
          pb = int'(sq_pos[plain_index(it.l2)]);
          ra = pa / Side;
          ca = pa % Side;
          rb = pb / Side;
          cb = pb % Side;
          if (ra == rb) begin
            // same row, doubled letters included: step right
            oa = ra * Side + (ca + 1) % Side;
            ob = rb * Side + (cb + 1) % Side;
          end else if (ca == cb) begin
            // same column: step down
            oa = ((ra + 1) % Side) * Side + ca;
            ob = ((rb + 1) % Side) * Side + cb;
          end else begin
            // rectangle: swap columns
            oa = ra * Side + cb;
            ob = rb * Side + ca;
          end
          res.one = sq_letter[oa];
          res.two = sq_letter[ob];
        end
      end
      default: begin
      end
    endcase
  endtask

  function automatic letter_t pick_plain_letter();
    return ($urandom_range(0, 9) == 0) ? letter_t'($urandom_range(26, 31))
                                       : letter_t'($urandom_range(0, 25));
  endfunction

  // mostly whole key sessions (key letters, key end, a run of pairs), some noise
  task automatic build_random_items();
    int n;
    stim_t row;
    while (stimulus.size() < DirectedCount + RandomItems) begin
      row = '0;
      row.l2 = letter_t'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        row.cmd = 2'($urandom_range(0, 3));
        row.l1 = letter_t'($urandom);
        stimulus.push_back(row);
      end else begin
        n = $urandom_range(0, 12);
        for (int k = 0; k < n; k++) begin
          row.l2 = letter_t'($urandom);
          if ($urandom_range(0, 15) == 0) begin
            // pair sent while the square is still open
            row.cmd = CMD_ENCRYPT;
            row.l1 = pick_plain_letter();
          end else begin
            row.cmd = CMD_KEY;
            row.l1 = ($urandom_range(0, 7) == 0) ? letter_t'($urandom)
                                                 : letter_t'($urandom_range(0, 25));
          end
          stimulus.push_back(row);
        end
        row.cmd = CMD_KEY_END;
        row.l1 = letter_t'($urandom);
        row.l2 = letter_t'($urandom);
        stimulus.push_back(row);
        n = $urandom_range(4, 40);
        for (int k = 0; k < n; k++) begin
          row.cmd = ($urandom_range(0, 31) == 0) ? CmdIgnored : CMD_ENCRYPT;
          row.l1 = pick_plain_letter();
          row.l2 = pick_plain_letter();
          stimulus.push_back(row);
        end
      end
    end
  endtask

  // source side: random gap, hold until accepted, then predict
  task automatic send_item(input stim_t it);
    int gap;
    bit has_out;
    cipher_t res;
    if ($urandom_range(0, 39) == 0) source_quiet = !source_quiet;
    gap = source_quiet ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= it.cmd;
    s_tdata <= {6'd0, it.l2, it.l1};
    do @(posedge clk); while (!s_tready);
    playfair_predict(it, has_out, res);
    if (has_out) pending_ciphers.push_back(it.typed ? it.want : res);
  endtask

  // sink side: random stall before each result, compare with the oldest expectation
  initial begin
    cipher_t want;
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      if (pending_ciphers.size() == 0) begin
        $display("%0t unexpected transfer: expected none, actual %h/%h",
                 $time, m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = pending_ciphers.pop_front();
        if (m_tdata[4:0] !== want.one) begin
          $display("%0t cipher_one: expected %0d, actual %0d", $time, want.one, m_tdata[4:0]);
          mismatch_count++;
        end
        if (m_tdata[9:5] !== want.two) begin
          $display("%0t cipher_two: expected %0d, actual %0d", $time, want.two, m_tdata[9:5]);
          mismatch_count++;
        end
        if (m_tuser[0] !== want.not_ready) begin
          $display("%0t not_ready: expected %0d, actual %0d", $time, want.not_ready, m_tuser[0]);
          mismatch_count++;
        end
      end
    end
  end

  // main sequence: reset, directed table, random sessions, drain
  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    mismatch_count = 0;
    cycle_count = 0;
    source_quiet = 1'b0;
    sink_quiet = 1'b0;
    foreach (placed[k]) placed[k] = 1'b0;
    fill_n = 0;
    sq_ready = 1'b0;
    for (int k = 0; k < DirectedCount; k++) stimulus.push_back(DirectedTable[k]);
    build_random_items();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (stimulus[k]) send_item(stimulus[k]);
    s_tvalid <= 1'b0;
    while (pending_ciphers.size() != 0) @(posedge clk);
    // trailing cycles catch any stray result
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
